// ----- rtl/core/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon test core.
`default_nettype none

package pip_pkg;

  // Coordinate width of one vertex or query point
  localparam int CoordBits   = 16;
  // Width of a coordinate difference and of a product of two differences
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * DiffBits;
  // Default vertex store depth
  localparam int MaxVertices = 64;
  // A polygon needs this many vertices before a query can hit it
  localparam int MinVertices = 3;

  // Command codes
  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic status;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } vertex_t;

  // Control of the shared multiply and compare unit
  typedef struct packed {
    logic load;  // keep this cycle's product as the held operand
    logic pos;   // edge runs upward: compare held < current, else the reverse
  } mul_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/point_in_polygon_test_core.sv -----
// Top level of the point-in-polygon test core: command sequencer and polygon state.
//
//   Port group   Direction  Handshake            Payload
//   in_*         input      in_valid/in_stall    pip_pkg::in_item_t  (opcode, coord_x, coord_y)
//   out_*        output     out_valid/out_stall  pip_pkg::out_item_t (inside_res, status)
//
// For clear, append and unused commands the result is registered. A query that
// passes the box and vertex-count checks runs through the transfer, a store read
// for the closing vertex, per edge a load state and the S_MUL1 and S_MUL2 states
// on the shared multiplier, and a result state.
// Reset (rst_n low, synchronous) empties the polygon and zeroes the box.
// A stalled result holds the output register and stalls new commands.
`default_nettype none

module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MaxVertices
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pip_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pip_pkg::out_item_t       out_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = pip_pkg::CoordBits;
  localparam int DW = pip_pkg::DiffBits;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREV,
    S_LOAD,
    S_MUL1,
    S_MUL2,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NW-1:0]          count_r, count_nxt;
  logic signed [CW-1:0]   min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic signed [CW-1:0]   min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  pip_pkg::vertex_t       pt_r, pt_nxt;
  pip_pkg::vertex_t       vj_r, vj_nxt;
  logic signed [DW-1:0]   dy_r, dy_nxt, lx_r, lx_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic                   cond_r, cond_nxt;
  logic                   pos_r, pos_nxt;
  logic                   inside_r, inside_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pip_pkg::out_item_t     out_data_r, out_data_nxt;

  logic                   accept;
  logic                   out_free;
  logic                   box_hit;
  logic                   enough;
  logic                   full;
  logic                   last;
  pip_pkg::vertex_t       in_v;

  logic                   wr_en;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  pip_pkg::vertex_t       rd_v;

  logic signed [DW-1:0]   mul_a, mul_b;
  pip_pkg::mul_ctrl_t     mctl;
  logic                   lt;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status of the stored polygon
  assign in_v.x  = in_data.coord_x;
  assign in_v.y  = in_data.coord_y;
  assign box_hit = (in_v.x >= min_x_r) && (in_v.x <= max_x_r) &&
                   (in_v.y >= min_y_r) && (in_v.y <= max_y_r);
  assign enough  = count_r >= NW'(pip_pkg::MinVertices);
  assign full    = count_r >= NW'(MAX_VERTICES);
  assign last    = (NW'(idx_r) == (count_r - NW'(1)));

  pip_vstore #(
    .DEPTH (MAX_VERTICES)
  ) u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_v),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_v)
  );

  // Feed the shared unit: first product lx*dy, second ex*ey
  assign mul_a    = (state_r == S_MUL1) ? lx_r : ex_r;
  assign mul_b    = (state_r == S_MUL1) ? dy_r : ey_r;
  assign mctl.load = (state_r == S_MUL1);
  assign mctl.pos  = pos_r;

  pip_mulcmp u_mulcmp (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .ctrl (mctl),
    .lt   (lt)
  );

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    min_x_nxt     = min_x_r;
    max_x_nxt     = max_x_r;
    min_y_nxt     = min_y_r;
    max_y_nxt     = max_y_r;
    idx_nxt       = idx_r;
    pt_nxt        = pt_r;
    vj_nxt        = vj_r;
    dy_nxt        = dy_r;
    lx_nxt        = lx_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    cond_nxt      = cond_r;
    pos_nxt       = pos_r;
    inside_nxt    = inside_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.inside_res = 1'b0;
          out_data_nxt.status     = 1'b0;
          case (in_data.opcode)
            pip_pkg::OpClear: begin
              count_nxt = '0;
              min_x_nxt = '0;
              max_x_nxt = '0;
              min_y_nxt = '0;
              max_y_nxt = '0;
            end
            pip_pkg::OpAppend: begin
              if (full) begin
                out_data_nxt.status = 1'b1;
              end else begin
                // Store vertex; first one seeds the box
                wr_en     = 1'b1;
                count_nxt = count_r + NW'(1);
                if (count_r == '0) begin
                  min_x_nxt = in_v.x;
                  max_x_nxt = in_v.x;
                  min_y_nxt = in_v.y;
                  max_y_nxt = in_v.y;
                end else begin
                  if (in_v.x < min_x_r) min_x_nxt = in_v.x;
                  if (in_v.x > max_x_r) max_x_nxt = in_v.x;
                  if (in_v.y < min_y_r) min_y_nxt = in_v.y;
                  if (in_v.y > max_y_r) max_y_nxt = in_v.y;
                end
              end
            end
            pip_pkg::OpQuery: begin
              if (box_hit && enough) begin
                // Start the edge walk at the closing vertex
                out_valid_nxt = 1'b0;
                pt_nxt        = in_v;
                inside_nxt    = 1'b0;
                rd_en         = 1'b1;
                rd_addr       = AW'(count_r - NW'(1));
                state_nxt     = S_PREV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PREV: begin
        vj_nxt    = rd_v;
        idx_nxt   = '0;
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // Form edge differences and the straddle test
        dy_nxt   = {vj_r.y[CW-1], vj_r.y} - {rd_v.y[CW-1], rd_v.y};
        lx_nxt   = {pt_r.x[CW-1], pt_r.x} - {rd_v.x[CW-1], rd_v.x};
        ex_nxt   = {vj_r.x[CW-1], vj_r.x} - {rd_v.x[CW-1], rd_v.x};
        ey_nxt   = {pt_r.y[CW-1], pt_r.y} - {rd_v.y[CW-1], rd_v.y};
        cond_nxt = ((rd_v.y <= pt_r.y) && (pt_r.y < vj_r.y)) ||
                   ((vj_r.y <= pt_r.y) && (pt_r.y < rd_v.y));
        pos_nxt  = vj_r.y > rd_v.y;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        // Toggle on a crossing, advance to the next edge
        if (cond_r && lt) begin
          inside_nxt = !inside_r;
        end
        vj_nxt = rd_v;
        if (last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          rd_en     = 1'b1;
          rd_addr   = idx_r + AW'(1);
          state_nxt = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.inside_res = inside_r;
          out_data_nxt.status     = 1'b0;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      min_x_r     <= '0;
      max_x_r     <= '0;
      min_y_r     <= '0;
      max_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_x_r     <= min_x_nxt;
      max_x_r     <= max_x_nxt;
      min_y_r     <= min_y_nxt;
      max_y_r     <= max_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    pt_r       <= pt_nxt;
    vj_r       <= vj_nxt;
    dy_r       <= dy_nxt;
    lx_r       <= lx_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    cond_r     <= cond_nxt;
    pos_r      <= pos_nxt;
    inside_r   <= inside_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/pip_vstore.sv -----
// Vertex store: one write port, one registered read port.
`default_nettype none

module pip_vstore #(
  parameter int DEPTH = pip_pkg::MaxVertices
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  wire pip_pkg::vertex_t                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]             rd_addr,
  output pip_pkg::vertex_t                          rd_data
);

  pip_pkg::vertex_t mem [DEPTH];

  // Write a vertex
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read a vertex; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pip_mulcmp.sv -----
// Shared multiplier with a held product and an exact product compare.
`default_nettype none

module pip_mulcmp (
  input  wire logic                                  clk,
  input  wire logic signed [pip_pkg::DiffBits-1:0]   op_a,
  input  wire logic signed [pip_pkg::DiffBits-1:0]   op_b,
  input  wire pip_pkg::mul_ctrl_t                    ctrl,
  output logic                                       lt
);

  logic signed [pip_pkg::ProdBits-1:0] prod;
  logic signed [pip_pkg::ProdBits-1:0] held_r;

  // Full-width signed product, exact for any pair of differences
  assign prod = pip_pkg::ProdBits'(op_a) * pip_pkg::ProdBits'(op_b);

  // Hold the first product of an edge
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      held_r <= prod;
    end
  end

  // Compare held and current products; flip order for downward edges
  assign lt = ctrl.pos ? (held_r < prod) : (prod < held_r);

endmodule

`default_nettype wire
